>>> sv/scs_pkg.sv
// ============================================================================
// scs_pkg
// Shared types, widths and constants of the twirl source coordinate pipeline.
// ============================================================================
package scs_pkg;

    // Coordinate and register widths
    localparam int COORD_BITS = 12;
    localparam int CFG_W      = 13;
    localparam int CX_W       = CFG_W - 1;
    localparam int TWIST_W    = 16;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0]  CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0]  CFG_TWIST_ANGLE  = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = CFG_W'(480);
    localparam logic [TWIST_W-1:0] RST_TWIST_ANGLE  = TWIST_W'(12288);

    // Default iteration count of both rotators
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // Distance path
    localparam int DW      = COORD_BITS + 2;      // signed offset from centre
    localparam int DIST_W  = 2 * DW;              // squared distance
    localparam int SQ_IN_W = DIST_W + 16;         // squared distance in Q.16
    localparam int SQ_W    = SQ_IN_W / 2;         // distance in Q.8

    // Angle path, signed Q3.16 radians
    localparam int XW = DW + 18;
    localparam int ZW = 20;
    localparam int AW = 23;
    localparam int WRAP_N = 4;
    localparam logic signed [ZW-1:0] PI_Q16      = ZW'(205887);
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
    localparam logic signed [AW-1:0] PI_Q16_A    = AW'(205887);
    localparam logic signed [AW-1:0] TWO_PI_Q16  = AW'(411775);

    // Twist term division
    localparam int DIFF_W = CX_W + 8;
    localparam int NUM_W  = TWIST_W + DIFF_W;
    localparam int QW     = DIFF_W;
    localparam int DEN_W  = CX_W + 4;

    // Rotation magnitude and result
    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] GAIN_Q16 = GAIN_W'(39797);
    localparam int MAG_W  = SQ_W + GAIN_W - 8;
    localparam int RW     = MAG_W + 3;
    localparam int SW     = RW + 1;
    localparam int NXW    = SW - 16;

    typedef struct packed {
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
    } t_scs_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] src_x;
        logic [COORD_BITS-1:0] src_y;
        logic                  keep_dest;
        logic                  in_circle;
    } t_scs_out;

    // atan(2^-i) in Q.16, zero from step 17 on.
    function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
        case (idx)
            0:       return ZW'(51472);
            1:       return ZW'(30386);
            2:       return ZW'(16055);
            3:       return ZW'(8150);
            4:       return ZW'(4091);
            5:       return ZW'(2047);
            6:       return ZW'(1024);
            7:       return ZW'(512);
            8:       return ZW'(256);
            9:       return ZW'(128);
            10:      return ZW'(64);
            11:      return ZW'(32);
            12:      return ZW'(16);
            13:      return ZW'(8);
            14:      return ZW'(4);
            15:      return ZW'(2);
            16:      return ZW'(1);
            default: return '0;
        endcase
    endfunction

endpackage

>>> sv/swirl_source_coordinate_top.sv
// ============================================================================
// swirl_source_coordinate_top
// Twirl warp source coordinate generator: one destination pixel in, one
// source pixel out, fully pipelined.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    i_in_data   (t_scs_in)
//   out      output     o_out_valid / i_out_ready  o_out_data  (t_scs_out)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request is taken every cycle while the skid register is empty. The path
// runs through the square root, divider and two rotator pipelines. Reset is
// synchronous, clears all valid bits and loads the configuration reset values.
// A stalled output parks one result in a skid register, and the whole
// pipeline then holds until it drains.
// ============================================================================
module swirl_source_coordinate_top import scs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_scs_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_scs_out             o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TWIST_W-1:0]   i_cfg_data
);
    localparam int CB = COORD_BITS;

    typedef struct packed {
        logic [CB-1:0]        x;
        logic [CB-1:0]        y;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 inc;
    } t_sq_tag;

    typedef struct packed {
        logic [CB-1:0]   x;
        logic [CB-1:0]   y;
        logic            inc;
        logic [SQ_W-1:0] d;
    } t_at_tag;

    typedef struct packed {
        logic [CB-1:0]        x;
        logic [CB-1:0]        y;
        logic                 inc;
        logic signed [ZW-1:0] ang;
        logic [MAG_W-1:0]     mag;
    } t_dv_tag;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          inc;
    } t_rt_tag;

    // ------------------------------------------------------------------
    // Configuration registers and derived geometry
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    r_frame_width;
    logic [CFG_W-1:0]    r_frame_height;
    logic [TWIST_W-1:0]  r_twist_angle;
    logic [2*CX_W-1:0]   r_rsq;
    logic [CX_W-1:0]     cx;
    logic [CX_W-1:0]     cy;
    logic [CX_W-1:0]     rad;
    logic                en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_twist_angle  <= RST_TWIST_ANGLE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[CFG_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[CFG_W-1:0];
                CFG_TWIST_ANGLE:  r_twist_angle  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    assign cx  = r_frame_width[CFG_W-1:1];
    assign cy  = r_frame_height[CFG_W-1:1];
    assign rad = (cx > cy) ? cx : cy;

    // Squared radius, stable while the block is idle after a write.
    always_ff @(posedge i_clk) begin
        r_rsq <= (2*CX_W)'(rad) * (2*CX_W)'(rad);
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets from the centre
    // ------------------------------------------------------------------
    logic                 r_s1_v;
    logic [CB-1:0]        r_s1_x;
    logic [CB-1:0]        r_s1_y;
    logic signed [DW-1:0] r_s1_dx;
    logic signed [DW-1:0] r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x  <= i_in_data.dest_x;
            r_s1_y  <= i_in_data.dest_y;
            r_s1_dx <= $signed(DW'(i_in_data.dest_x)) - $signed(DW'(cx));
            r_s1_dy <= $signed(DW'(i_in_data.dest_y)) - $signed(DW'(cy));
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the offsets
    // ------------------------------------------------------------------
    logic                 r_s2_v;
    logic [CB-1:0]        r_s2_x;
    logic [CB-1:0]        r_s2_y;
    logic signed [DW-1:0] r_s2_dx;
    logic signed [DW-1:0] r_s2_dy;
    logic [DIST_W-1:0]    r_s2_dx2;
    logic [DIST_W-1:0]    r_s2_dy2;
    logic signed [DIST_W-1:0] dxe;
    logic signed [DIST_W-1:0] dye;

    assign dxe = DIST_W'(r_s1_dx);
    assign dye = DIST_W'(r_s1_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_x   <= r_s1_x;
            r_s2_y   <= r_s1_y;
            r_s2_dx  <= r_s1_dx;
            r_s2_dy  <= r_s1_dy;
            r_s2_dx2 <= $unsigned(dxe * dxe);
            r_s2_dy2 <= $unsigned(dye * dye);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared distance and the circle test
    // ------------------------------------------------------------------
    logic              r_s3_v;
    t_sq_tag           r_s3_tag;
    logic [DIST_W-1:0] r_s3_dist2;
    logic [DIST_W-1:0] dist2;

    assign dist2 = r_s2_dx2 + r_s2_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_dist2     <= dist2;
            r_s3_tag.x     <= r_s2_x;
            r_s3_tag.y     <= r_s2_y;
            r_s3_tag.dx    <= r_s2_dx;
            r_s3_tag.dy    <= r_s2_dy;
            r_s3_tag.inc   <= (dist2 <= DIST_W'(r_rsq));
        end
    end

    // ------------------------------------------------------------------
    // Distance in Q.8
    // ------------------------------------------------------------------
    logic            sq_v;
    logic [SQ_W-1:0] sq_root;
    t_sq_tag         sq_tag;

    scs_isqrt #(
        .TAG_W ($bits(t_sq_tag))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_rad   ({r_s3_dist2, 16'b0}),
        .i_tag   (r_s3_tag),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    // ------------------------------------------------------------------
    // Polar angle of the offset
    // ------------------------------------------------------------------
    t_at_tag              at_in_tag;
    t_at_tag              at_tag;
    logic                 at_v;
    logic signed [ZW-1:0] at_ang;

    assign at_in_tag.x   = sq_tag.x;
    assign at_in_tag.y   = sq_tag.y;
    assign at_in_tag.inc = sq_tag.inc;
    assign at_in_tag.d   = sq_root;

    scs_cordic_vec #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .TAG_W        ($bits(t_at_tag))
    ) u_cordic_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_dx    (sq_tag.dx),
        .i_dy    (sq_tag.dy),
        .i_tag   (at_in_tag),
        .o_valid (at_v),
        .o_ang   (at_ang),
        .o_tag   (at_tag)
    );

    // ------------------------------------------------------------------
    // Stage 4: twist numerator and scaled rotation magnitude
    // ------------------------------------------------------------------
    localparam int DF_W   = SQ_W + 2;
    localparam int PROD_W = SQ_W + GAIN_W;

    logic                   r_s4_v;
    t_dv_tag                r_s4_tag;
    logic [NUM_W-1:0]       r_s4_num;
    logic signed [DF_W-1:0] diff_s;
    logic [DIFF_W-1:0]      diff;
    logic [PROD_W-1:0]      mag_full;

    assign diff_s   = $signed(DF_W'({rad, 8'b0})) - $signed(DF_W'(at_tag.d));
    assign diff     = diff_s[DF_W-1] ? '0 : diff_s[DIFF_W-1:0];
    assign mag_full = PROD_W'(at_tag.d) * PROD_W'(GAIN_Q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= at_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_num     <= NUM_W'(r_twist_angle) * NUM_W'(diff);
            r_s4_tag.x   <= at_tag.x;
            r_s4_tag.y   <= at_tag.y;
            r_s4_tag.inc <= at_tag.inc;
            r_s4_tag.ang <= at_ang;
            r_s4_tag.mag <= mag_full[PROD_W-1:8];
        end
    end

    // ------------------------------------------------------------------
    // Twist term: numerator over 16 times the radius
    // ------------------------------------------------------------------
    logic          dv_v;
    logic [QW-1:0] dv_quo;
    t_dv_tag       dv_tag;

    scs_divider #(
        .TAG_W ($bits(t_dv_tag))
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_num   (r_s4_num),
        .i_den   ({rad, 4'b0}),
        .i_tag   (r_s4_tag),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_tag   (dv_tag)
    );

    // ------------------------------------------------------------------
    // Stage 5 and the wrap stages: angle plus twist, brought to at most pi
    // ------------------------------------------------------------------
    logic signed [AW-1:0] term;
    logic                 r_wr_v   [WRAP_N+1];
    logic signed [AW-1:0] r_wr_a   [WRAP_N+1];
    logic [MAG_W-1:0]     r_wr_mag [WRAP_N+1];
    t_rt_tag              r_wr_tag [WRAP_N+1];

    // A zero radius has no twist.
    assign term = (rad == '0) ? '0 : $signed(AW'(dv_quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_v[0] <= 1'b0;
        end else if (en) begin
            r_wr_v[0] <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wr_a[0]       <= AW'(dv_tag.ang) + term;
            r_wr_mag[0]     <= dv_tag.mag;
            r_wr_tag[0].x   <= dv_tag.x;
            r_wr_tag[0].y   <= dv_tag.y;
            r_wr_tag[0].inc <= dv_tag.inc;
        end
    end

    for (genvar j = 0; j < WRAP_N; j++) begin : g_wrap
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wr_v[j+1] <= 1'b0;
            end else if (en) begin
                r_wr_v[j+1] <= r_wr_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_wr_a[j+1]   <= (r_wr_a[j] > PI_Q16_A) ? r_wr_a[j] - TWO_PI_Q16 : r_wr_a[j];
                r_wr_mag[j+1] <= r_wr_mag[j];
                r_wr_tag[j+1] <= r_wr_tag[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation of the distance by the twisted angle
    // ------------------------------------------------------------------
    logic                 rt_v;
    logic signed [RW-1:0] rt_x;
    logic signed [RW-1:0] rt_y;
    t_rt_tag              rt_tag;

    scs_cordic_rot #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .TAG_W        ($bits(t_rt_tag))
    ) u_cordic_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_wr_v[WRAP_N]),
        .i_mag   (r_wr_mag[WRAP_N]),
        .i_ang   (ZW'(r_wr_a[WRAP_N])),
        .i_tag   (r_wr_tag[WRAP_N]),
        .o_valid (rt_v),
        .o_x     (rt_x),
        .o_y     (rt_y),
        .o_tag   (rt_tag)
    );

    // ------------------------------------------------------------------
    // Stage 6: source coordinate, truncated toward zero, and frame check
    // ------------------------------------------------------------------
    logic signed [SW-1:0]  sx;
    logic signed [SW-1:0]  sy;
    logic signed [SW-1:0]  neg_sx;
    logic signed [SW-1:0]  neg_sy;
    logic signed [NXW-1:0] nx;
    logic signed [NXW-1:0] ny;
    logic                  in_frame;
    logic                  r_fin_v;
    t_scs_out              r_fin;

    assign sx     = ($signed(SW'(cx)) <<< 16) + SW'(rt_x);
    assign sy     = ($signed(SW'(cy)) <<< 16) + SW'(rt_y);
    assign neg_sx = -sx;
    assign neg_sy = -sy;
    assign nx     = sx[SW-1] ? -NXW'(neg_sx >>> 16) : NXW'(sx >>> 16);
    assign ny     = sy[SW-1] ? -NXW'(neg_sy >>> 16) : NXW'(sy >>> 16);
    assign in_frame = !nx[NXW-1] && !ny[NXW-1]
                   && (nx[NXW-2:0] < (NXW-1)'(r_frame_width))
                   && (ny[NXW-2:0] < (NXW-1)'(r_frame_height));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (en) begin
            r_fin_v <= rt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fin.in_circle <= rt_tag.inc;
            r_fin.keep_dest <= rt_tag.inc && !in_frame;
            if (rt_tag.inc && in_frame) begin
                r_fin.src_x <= nx[CB-1:0];
                r_fin.src_y <= ny[CB-1:0];
            end else begin
                r_fin.src_x <= rt_tag.x;
                r_fin.src_y <= rt_tag.y;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid register behind it
    // ------------------------------------------------------------------
    logic     r_out_v;
    t_scs_out r_out;
    logic     r_skid_v;
    t_scs_out r_skid;

    assign en          = !r_skid_v;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !i_out_ready) begin
            if (r_fin_v && !r_skid_v) begin
                r_skid_v <= 1'b1;
            end
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= r_fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_out_ready) begin
            if (!r_skid_v) begin
                r_skid <= r_fin;
            end
        end else if (r_skid_v) begin
            r_out <= r_skid;
        end else begin
            r_out <= r_fin;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A parked result always has a result ahead of it.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output is empty");

    // A finished result meeting a stalled output is parked, not dropped.
    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_ready && r_fin_v && !r_skid_v) |=> r_skid_v)
        else $error("finished result lost on output stall");

    // A pixel outside the circle never asks to keep the destination.
    a_keep_in_circle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.keep_dest) |-> o_out_data.in_circle)
        else $error("keep_dest set for a pixel outside the circle");

endmodule

>>> sv/scs_isqrt.sv
// ============================================================================
// scs_isqrt
// Pipelined integer square root, one result bit per stage.
// ============================================================================
module scs_isqrt import scs_pkg::*; #(
    parameter int TAG_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SQ_IN_W-1:0] i_rad,
    input  logic [TAG_W-1:0]   i_tag,
    output logic               o_valid,
    output logic [SQ_W-1:0]    o_root,
    output logic [TAG_W-1:0]   o_tag
);
    localparam int REM_W = SQ_W + 2;

    logic               r_v    [SQ_W];
    logic [SQ_IN_W-1:0] r_rad  [SQ_W];
    logic [REM_W-1:0]   r_rem  [SQ_W];
    logic [SQ_W-1:0]    r_root [SQ_W];
    logic [TAG_W-1:0]   r_tag  [SQ_W];

    for (genvar k = 0; k < SQ_W; k++) begin : g_stage
        logic               v_in;
        logic [SQ_IN_W-1:0] rad_in;
        logic [REM_W-1:0]   rem_in;
        logic [SQ_W-1:0]    root_in;
        logic [TAG_W-1:0]   tag_in;
        logic [REM_W+1:0]   rem_sh;
        logic [REM_W+1:0]   trial;
        logic               take;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign tag_in  = r_tag[k-1];
        end

        // Bring down two bits and try the next root bit.
        assign rem_sh = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= rad_in << 2;
                r_rem[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                r_root[k] <= {root_in[SQ_W-2:0], take};
                r_tag[k]  <= tag_in;
            end
        end
    end

    assign o_valid = r_v[SQ_W-1];
    assign o_root  = r_root[SQ_W-1];
    assign o_tag   = r_tag[SQ_W-1];

endmodule

>>> sv/scs_cordic_vec.sv
// ============================================================================
// scs_cordic_vec
// Pipelined vectoring rotator that gives the angle of (dx, dy) in Q3.16.
// ============================================================================
module scs_cordic_vec import scs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int TAG_W        = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_ang,
    output logic [TAG_W-1:0]     o_tag
);
    localparam int N = CORDIC_STEPS + 1;

    logic                 r_v   [N];
    logic signed [XW-1:0] r_x   [N];
    logic signed [XW-1:0] r_y   [N];
    logic signed [ZW-1:0] r_z   [N];
    logic [TAG_W-1:0]     r_tag [N];

    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;

    assign x0 = XW'(i_dx) <<< 16;
    assign y0 = XW'(i_dy) <<< 16;

    // Pre-rotation by pi for the left half plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            if (x0 < 0) begin
                r_x[0] <= -x0;
                r_y[0] <= -y0;
                r_z[0] <= (y0 >= 0) ? PI_Q16 : -PI_Q16;
            end else begin
                r_x[0] <= x0;
                r_y[0] <= y0;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        // Drive y toward zero and sum the turned angles.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[i+1] <= r_tag[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + atan_q16(i);
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - atan_q16(i);
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_ang   = r_z[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

>>> sv/scs_divider.sv
// ============================================================================
// scs_divider
// Pipelined restoring divider for the twist term, one quotient bit per stage.
// ============================================================================
module scs_divider import scs_pkg::*; #(
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [TAG_W-1:0] o_tag
);
    localparam int HI_W = NUM_W - QW;

    logic             r_v   [QW];
    logic [HI_W-1:0]  r_rem [QW];
    logic [QW-1:0]    r_low [QW];
    logic [QW-1:0]    r_quo [QW];
    logic [TAG_W-1:0] r_tag [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic             v_in;
        logic [HI_W-1:0]  rem_in;
        logic [QW-1:0]    low_in;
        logic [QW-1:0]    quo_in;
        logic [TAG_W-1:0] tag_in;
        logic [HI_W:0]    rem_sh;
        logic             take;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = i_num[NUM_W-1:QW];
            assign low_in = i_num[QW-1:0];
            assign quo_in = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign quo_in = r_quo[k-1];
            assign tag_in = r_tag[k-1];
        end

        // Shift in the next dividend bit and subtract where it fits.
        assign rem_sh = {rem_in, low_in[QW-1]};
        assign take   = (rem_sh >= (HI_W+1)'(i_den));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? HI_W'(rem_sh - (HI_W+1)'(i_den)) : HI_W'(rem_sh);
                r_low[k] <= low_in << 1;
                r_quo[k] <= {quo_in[QW-2:0], take};
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

>>> sv/scs_cordic_rot.sv
// ============================================================================
// scs_cordic_rot
// Pipelined rotating rotator that turns (mag, 0) by a Q3.16 angle.
// ============================================================================
module scs_cordic_rot import scs_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int TAG_W        = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [MAG_W-1:0]     i_mag,
    input  logic signed [ZW-1:0] i_ang,
    input  logic [TAG_W-1:0]     i_tag,
    output logic                 o_valid,
    output logic signed [RW-1:0] o_x,
    output logic signed [RW-1:0] o_y,
    output logic [TAG_W-1:0]     o_tag
);
    localparam int N = CORDIC_STEPS + 1;

    logic                 r_v   [N];
    logic signed [RW-1:0] r_x   [N];
    logic signed [RW-1:0] r_y   [N];
    logic signed [ZW-1:0] r_z   [N];
    logic [TAG_W-1:0]     r_tag [N];

    logic signed [RW-1:0] mag;

    assign mag = $signed(RW'(i_mag));

    // Pre-rotation by pi brings the angle within a quarter turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_y[0]   <= '0;
            if (i_ang > HALF_PI_Q16) begin
                r_x[0] <= -mag;
                r_z[0] <= i_ang - PI_Q16;
            end else if (i_ang < -HALF_PI_Q16) begin
                r_x[0] <= -mag;
                r_z[0] <= i_ang + PI_Q16;
            end else begin
                r_x[0] <= mag;
                r_z[0] <= i_ang;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [RW-1:0] xs;
        logic signed [RW-1:0] ys;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        // Drive the residual angle toward zero.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[i+1] <= r_tag[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - atan_q16(i);
                end else begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + atan_q16(i);
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_x     = r_x[N-1];
    assign o_y     = r_y[N-1];
    assign o_tag   = r_tag[N-1];

endmodule
